FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the rotary position rotate block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define RPR_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Assertion on the block clock clk_i and reset rst_ni.
`define RPR_ASSERT(lbl, prop, msg) `RPR_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Types and fixed constants shared by the rotary position rotate modules.
// ----------------------------------------------------------------------------
package rpr_pkg;

  // Extra fraction bits carried through the CORDIC datapath.
  localparam int unsigned GUARD_BITS    = 10;
  // Angle accumulator width, radians in Q30.
  localparam int unsigned Z_WIDTH       = 32;
  localparam int unsigned CORDIC_STAGES = 24;
  // Fixed widths of the position and pair index fields of an item.
  localparam int unsigned POS_FIELD_W   = 16;
  localparam int unsigned PAIR_FIELD_W  = 5;

  // Coarse pre-rotation by quarter turns.
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } rpr_quad_e;

  // Control that travels with every item down the pipeline.
  typedef struct packed {
    logic valid;
    logic bypass;
  } rpr_ctl_t;

  // Unsigned quotient by shift and subtract, for tables built at elaboration.
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

endpackage

FILE: design/rpr_front.sv
// ----------------------------------------------------------------------------
// rpr_front
// Frequency lookup, phase product, quadrant split and residual angle setup.
// ----------------------------------------------------------------------------
module rpr_front import rpr_pkg::*; #(
  parameter int unsigned HEAD_SIZE     = 64,
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned DATA_BITS     = 16,
  parameter int unsigned CW            = 28
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic                        kind_i,
  input  logic signed [DATA_BITS-1:0] x_i,
  input  logic signed [DATA_BITS-1:0] y_i,
  input  logic [POS_FIELD_W-1:0]      position_i,
  input  logic [PAIR_FIELD_W-1:0]     pair_index_i,
  output rpr_ctl_t                    ctl_o,
  output logic signed [CW-1:0]        a_o,
  output logic signed [CW-1:0]        b_o,
  output logic signed [Z_WIDTH-1:0]   z_o
);

  localparam int unsigned PW = (POSITION_BITS < POS_FIELD_W) ? POSITION_BITS : POS_FIELD_W;
  localparam int unsigned ROM_DEPTH = 1 << PAIR_FIELD_W;
  localparam int unsigned MAG_W  = 30;
  localparam int unsigned ZPROD_W = MAG_W + 32;
  localparam int unsigned EXT_W  = CW - DATA_BITS - GUARD_BITS;

  localparam longint unsigned BASE_LOG2_Q32  = 64'd57070290109;
  localparam longint unsigned LN2_Q32        = 64'd2977044472;
  localparam longint unsigned INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic [31:0]     TWO_PI_Q29     = 32'd3373259426;
  localparam int unsigned     SERIES_TERMS   = 20;

  // exp(-x), x and result in Q32, by a truncated power series.
  function automatic longint unsigned exp_neg_q32(longint unsigned x);
    longint          sum;
    longint unsigned term;
    sum  = longint'(64'd1 << 32);
    term = 64'd1 << 32;
    for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
      term = div_u64((term * x) >> 32, 64'(n));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // Turns per position for pair k, Q0.32.
  function automatic logic [31:0] freq_entry(int unsigned k);
    longint unsigned e;
    longint unsigned f;
    longint unsigned g;
    int unsigned     whole;
    if (2 * k >= HEAD_SIZE) begin
      return 32'd0;
    end
    e     = div_u64(64'(2 * k) * BASE_LOG2_Q32, 64'(HEAD_SIZE));
    whole = 32'(e >> 32);
    f     = e & 64'hFFFF_FFFF;
    g     = exp_neg_q32((f * LN2_Q32) >> 32);
    return 32'(((g * INV_TWO_PI_Q32) >> 32) >> whole);
  endfunction

  logic [31:0] freq_tab [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [31:0] FREQ = freq_entry(g);
    assign freq_tab[g] = FREQ;
  end

  // Stage 1: table lookup.
  rpr_ctl_t                 ctl1_q;
  logic                     kind1_q;
  logic signed [DATA_BITS-1:0] x1_q, y1_q;
  logic [PW-1:0]            pos1_q;
  logic [31:0]              freq1_q;
  logic                     bypass_d;

  assign bypass_d = ({3'b000, pair_index_i, 1'b0} >= 9'(HEAD_SIZE));

  // Stage 2: phase product.
  rpr_ctl_t                 ctl2_q;
  logic                     kind2_q;
  logic signed [DATA_BITS-1:0] x2_q, y2_q;
  logic [31:0]              phase2_q;
  logic [PW+31:0]           phase_prod;

  assign phase_prod = (PW + 32)'(pos1_q) * (PW + 32)'(freq1_q);

  // Stage 3: direction, quadrant and residual magnitude.
  rpr_ctl_t                 ctl3_q;
  logic signed [DATA_BITS-1:0] x3_q, y3_q;
  rpr_quad_e                quad3_q;
  logic                     neg3_q;
  logic [MAG_W-1:0]         mag3_q;
  logic [31:0]              ph, ph_rnd, resid, mag;
  rpr_quad_e                quad_d;

  always_comb begin
    ph     = kind2_q ? (32'd0 - phase2_q) : phase2_q;
    ph_rnd = ph + 32'h2000_0000;
    // Pairs past the head keep their orientation.
    quad_d = ctl2_q.bypass ? QUAD_0 : rpr_quad_e'(ph_rnd[31:30]);
    resid  = {ph[31:30] - ph_rnd[31:30], ph[29:0]};
    mag    = resid[31] ? (32'd0 - resid) : resid;
  end

  // Stage 4: residual to radians and quarter-turn pre-rotation.
  rpr_ctl_t                 ctl4_q;
  logic                     neg4_q;
  logic [MAG_W-1:0]         zmag4_q;
  logic signed [CW-1:0]     a4_q, b4_q;
  logic [ZPROD_W-1:0]       zprod;
  logic signed [CW-1:0]     ax, bx, a4_d, b4_d;

  assign zprod = ZPROD_W'(mag3_q) * ZPROD_W'(TWO_PI_Q29);
  assign ax    = {{EXT_W{x3_q[DATA_BITS-1]}}, x3_q, {GUARD_BITS{1'b0}}};
  assign bx    = {{EXT_W{y3_q[DATA_BITS-1]}}, y3_q, {GUARD_BITS{1'b0}}};

  always_comb begin
    case (quad3_q)
      QUAD_90: begin
        a4_d = -bx;
        b4_d = ax;
      end
      QUAD_180: begin
        a4_d = -ax;
        b4_d = -bx;
      end
      QUAD_270: begin
        a4_d = bx;
        b4_d = -ax;
      end
      default: begin
        a4_d = ax;
        b4_d = bx;
      end
    endcase
  end

  // Stage 5: signed residual angle.
  rpr_ctl_t                   ctl5_q;
  logic signed [CW-1:0]       a5_q, b5_q;
  logic signed [Z_WIDTH-1:0]  z5_q;
  logic signed [Z_WIDTH-1:0]  zpos;

  assign zpos = Z_WIDTH'(zmag4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      ctl1_q <= '{valid: valid_i, bypass: bypass_d};
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q  <= kind_i;
      x1_q     <= x_i;
      y1_q     <= y_i;
      pos1_q   <= position_i[PW-1:0];
      freq1_q  <= freq_tab[pair_index_i];

      kind2_q  <= kind1_q;
      x2_q     <= x1_q;
      y2_q     <= y1_q;
      phase2_q <= phase_prod[31:0];

      x3_q     <= x2_q;
      y3_q     <= y2_q;
      quad3_q  <= quad_d;
      neg3_q   <= resid[31];
      mag3_q   <= mag[MAG_W-1:0];

      neg4_q   <= neg3_q;
      zmag4_q  <= zprod[MAG_W+30:31];
      a4_q     <= a4_d;
      b4_q     <= b4_d;

      a5_q     <= a4_q;
      b5_q     <= b4_q;
      z5_q     <= neg4_q ? -zpos : zpos;
    end
  end

  assign ctl_o = ctl5_q;
  assign a_o   = a5_q;
  assign b_o   = b5_q;
  assign z_o   = z5_q;

endmodule

FILE: design/rpr_cell.sv
// ----------------------------------------------------------------------------
// rpr_cell
// One CORDIC micro-rotation stage; a row of these forms the rotator.
// ----------------------------------------------------------------------------
module rpr_cell import rpr_pkg::*; #(
  parameter int unsigned CW    = 28,
  parameter int unsigned SHIFT = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  rpr_ctl_t                   ctl_i,
  input  logic signed [CW-1:0]       a_i,
  input  logic signed [CW-1:0]       b_i,
  input  logic signed [Z_WIDTH-1:0]  z_i,
  output rpr_ctl_t                   ctl_o,
  output logic signed [CW-1:0]       a_o,
  output logic signed [CW-1:0]       b_o,
  output logic signed [Z_WIDTH-1:0]  z_o
);

  // atan(2^-i) in Q30, from the arctangent series in Q60 rounded to Q30.
  function automatic longint atan_q30(int unsigned i);
    longint s;
    longint t;
    s = 0;
    if (i == 0) begin
      return 64'sd843314857;
    end
    for (int unsigned n = 0; n < 31; n++) begin
      if (i * (2 * n + 1) <= 60) begin
        t = longint'(div_u64(64'd1 << (60 - i * (2 * n + 1)), 64'(2 * n + 1)));
        s = (n % 2 == 1) ? (s - t) : (s + t);
      end
    end
    return (s + (64'sd1 << 29)) >>> 30;
  endfunction

  localparam logic signed [Z_WIDTH-1:0] ATAN = Z_WIDTH'(atan_q30(SHIFT));

  rpr_ctl_t                  ctl_q;
  logic signed [CW-1:0]      a_q, b_q, a_d, b_d, da, db;
  logic signed [Z_WIDTH-1:0] z_q, z_d;

  assign da = b_i >>> SHIFT;
  assign db = a_i >>> SHIFT;

  always_comb begin
    if (ctl_i.bypass) begin
      a_d = a_i;
      b_d = b_i;
      z_d = z_i;
    end else if (!z_i[Z_WIDTH-1]) begin
      a_d = a_i - da;
      b_d = b_i + db;
      z_d = z_i - ATAN;
    end else begin
      a_d = a_i + da;
      b_d = b_i - db;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign a_o   = a_q;
  assign b_o   = b_q;
  assign z_o   = z_q;

endmodule

FILE: design/rpr_gain.sv
// ----------------------------------------------------------------------------
// rpr_gain
// CORDIC gain compensation, rounding and saturation to the data width.
// ----------------------------------------------------------------------------
module rpr_gain import rpr_pkg::*; #(
  parameter int unsigned DATA_BITS = 16,
  parameter int unsigned CW        = 28
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  rpr_ctl_t                    ctl_i,
  input  logic signed [CW-1:0]        a_i,
  input  logic signed [CW-1:0]        b_i,
  output rpr_ctl_t                    ctl_o,
  output logic signed [DATA_BITS-1:0] x_o,
  output logic signed [DATA_BITS-1:0] y_o
);

  localparam int unsigned PROD_W  = CW + 21;
  localparam int unsigned SHIFT_W = GUARD_BITS + 20;
  localparam logic signed [20:0] GAIN_Q20 = 21'sd636751;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (SHIFT_W - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W - DATA_BITS + 1){1'b0}}, {(DATA_BITS - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO =
    {{(PROD_W - DATA_BITS + 1){1'b1}}, {(DATA_BITS - 1){1'b0}}};

  function automatic logic [DATA_BITS-1:0] round_sat(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + ROUND_BIAS) >>> SHIFT_W;
    if (r > SAT_HI) begin
      return SAT_HI[DATA_BITS-1:0];
    end else if (r < SAT_LO) begin
      return SAT_LO[DATA_BITS-1:0];
    end
    return r[DATA_BITS-1:0];
  endfunction

  rpr_ctl_t                    ctl1_q, ctl2_q;
  logic signed [PROD_W-1:0]    pa1_q, pb1_q, pa_d, pb_d;
  logic signed [DATA_BITS-1:0] rx1_q, ry1_q, x2_q, y2_q;

  assign pa_d = a_i * GAIN_Q20;
  assign pb_d = b_i * GAIN_Q20;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa1_q <= pa_d;
      pb1_q <= pb_d;
      // A bypassed pair left the rotator unchanged, guard bits still zero.
      rx1_q <= a_i[GUARD_BITS +: DATA_BITS];
      ry1_q <= b_i[GUARD_BITS +: DATA_BITS];
      x2_q  <= ctl1_q.bypass ? rx1_q : round_sat(pa1_q);
      y2_q  <= ctl1_q.bypass ? ry1_q : round_sat(pb1_q);
    end
  end

  assign ctl_o = ctl2_q;
  assign x_o   = x2_q;
  assign y_o   = y2_q;

endmodule

FILE: design/rotary_position_rotate_unit.sv
// ----------------------------------------------------------------------------
// rotary_position_rotate_unit
// Rotary position embedding: rotates one (x, y) pair per item by the angle
// position * 10000^(-2k/HEAD_SIZE), or by its negative when s_axis_tuser is 1.
// The slave channel takes one item per clock while s_axis_tready is high;
// tdata carries x_value, y_value, position and pair_index, tuser the direction.
// The master channel returns x_rotated and y_rotated, saturated to DATA_BITS.
// Pipeline: m_axis_tvalid rises once an accepted item has passed five setup
// stages (frequency table, phase product, quadrant, angle scaling, sign),
// 24 CORDIC cells, two gain stages and the output register.
// Throughput: one item per cycle while m_axis_tready stays high; the CORDIC
// row is fully pipelined, so the rate is set by the single-item cell stride.
// When the receiver stalls, one result waits in the output register and the
// next lands in a skid register; only then does s_axis_tready drop and the
// whole pipeline hold. s_axis_tready is a register output.
// Reset clears all valid flags; the frequency and arctangent tables are
// constants, so the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotary_position_rotate_unit import rpr_pkg::*; #(
  parameter int unsigned HEAD_SIZE     = 64,
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned DATA_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  // x_value, y_value, position, pair_index (from bit 0 up), zero padded
  input  logic [((2 * DATA_BITS + POS_FIELD_W + PAIR_FIELD_W + 7) / 8) * 8 - 1:0]
                     s_axis_tdata,
  // kind
  input  logic       s_axis_tuser,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  // x_rotated, y_rotated (from bit 0 up), zero padded
  output logic [((2 * DATA_BITS + 7) / 8) * 8 - 1:0]
                     m_axis_tdata
);

  localparam int unsigned CW    = DATA_BITS + GUARD_BITS + 2;
  localparam int unsigned OUT_W = ((2 * DATA_BITS + 7) / 8) * 8;

  logic en;

  rpr_ctl_t                  ctl_s [CORDIC_STAGES + 1];
  logic signed [CW-1:0]      a_s   [CORDIC_STAGES + 1];
  logic signed [CW-1:0]      b_s   [CORDIC_STAGES + 1];
  logic signed [Z_WIDTH-1:0] z_s   [CORDIC_STAGES + 1];

  rpr_front #(
    .HEAD_SIZE    (HEAD_SIZE),
    .POSITION_BITS(POSITION_BITS),
    .DATA_BITS    (DATA_BITS),
    .CW           (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .kind_i      (s_axis_tuser),
    .x_i         (s_axis_tdata[DATA_BITS-1:0]),
    .y_i         (s_axis_tdata[2*DATA_BITS-1:DATA_BITS]),
    .position_i  (s_axis_tdata[2*DATA_BITS +: POS_FIELD_W]),
    .pair_index_i(s_axis_tdata[2*DATA_BITS+POS_FIELD_W +: PAIR_FIELD_W]),
    .ctl_o       (ctl_s[0]),
    .a_o         (a_s[0]),
    .b_o         (b_s[0]),
    .z_o         (z_s[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rpr_cell #(
      .CW   (CW),
      .SHIFT(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (ctl_s[g]),
      .a_i   (a_s[g]),
      .b_i   (b_s[g]),
      .z_i   (z_s[g]),
      .ctl_o (ctl_s[g+1]),
      .a_o   (a_s[g+1]),
      .b_o   (b_s[g+1]),
      .z_o   (z_s[g+1])
    );
  end

  rpr_ctl_t                    g_ctl;
  logic signed [DATA_BITS-1:0] g_x, g_y;

  rpr_gain #(
    .DATA_BITS(DATA_BITS),
    .CW       (CW)
  ) u_gain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctl_i (ctl_s[CORDIC_STAGES]),
    .a_i   (a_s[CORDIC_STAGES]),
    .b_i   (b_s[CORDIC_STAGES]),
    .ctl_o (g_ctl),
    .x_o   (g_x),
    .y_o   (g_y)
  );

  // Output register plus one skid entry.
  logic                 out_vld_q, out_vld_d, skid_vld_q, skid_vld_d, out_fire;
  logic [DATA_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [DATA_BITS-1:0] skid_x_q, skid_x_d, skid_y_q, skid_y_d;

  assign en       = !skid_vld_q;
  assign out_fire = out_vld_q && m_axis_tready;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    skid_vld_d = skid_vld_q;
    skid_x_d   = skid_x_q;
    skid_y_d   = skid_y_q;
    if (skid_vld_q) begin
      if (out_fire) begin
        out_x_d    = skid_x_q;
        out_y_d    = skid_y_q;
        skid_vld_d = 1'b0;
      end
    end else if (g_ctl.valid) begin
      if (!out_vld_q || out_fire) begin
        out_vld_d = 1'b1;
        out_x_d   = g_x;
        out_y_d   = g_y;
      end else begin
        skid_vld_d = 1'b1;
        skid_x_d   = g_x;
        skid_y_d   = g_y;
      end
    end else if (out_fire) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    skid_x_q <= skid_x_d;
    skid_y_q <= skid_y_d;
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_y_q, out_x_q});

  `RPR_ASSERT(a_skid_needs_out, skid_vld_q |-> out_vld_q, "skid entry held with empty output")
  `RPR_ASSERT(a_skid_fill_cause, $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready), "skid filled without a stalled output")
  `RPR_ASSERT(a_skid_hold, skid_vld_q && !m_axis_tready |=> skid_vld_q, "skid entry lost during a stall")

endmodule

FILE: bench/tb_rotary_position_rotate_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotary_position_rotate_unit
// Streams element pairs through the rotary position rotate unit and checks
// every returned pair against a bit-exact software rotation. The run has a
// short directed sweep and then random items, with idling on both sides and
// one long receiver hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_rotary_position_rotate_unit import rpr_pkg::*;;

  localparam int unsigned HEAD_SIZE     = 64;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned DATA_BITS     = 16;

  localparam int unsigned S_TDATA_W =
      ((2 * DATA_BITS + POS_FIELD_W + PAIR_FIELD_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((2 * DATA_BITS + 7) / 8) * 8;
  localparam int unsigned PAIR_SLOTS = 1 << PAIR_FIELD_W;

  // Fixed-point constants of the frequency table and the CORDIC row.
  localparam longint unsigned BASE_LOG2_Q32  = 64'd57070290109;
  localparam longint unsigned LN2_Q32        = 64'd2977044472;
  localparam longint unsigned INV_TWO_PI_Q32 = 64'd683565276;
  localparam longint unsigned TWO_PI_Q29     = 64'd3373259426;
  localparam longint          QUARTER_PI_Q30 = 64'sd843314857;
  localparam longint          GAIN_Q20       = 64'sd636751;
  localparam int unsigned     SERIES_TERMS   = 20;

  localparam longint SAMPLE_MAX = 2 ** (DATA_BITS - 1) - 1;
  localparam longint SAMPLE_MIN = -(2 ** (DATA_BITS - 1));

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_PER_PHASE = 160;

  typedef logic signed [DATA_BITS-1:0] sample_t;
  typedef longint unsigned u64_t;

  typedef struct {
    sample_t xr;
    sample_t yr;
  } rotated_pair_t;

  class rope_scoreboard;
    bit [31:0]     turn_rate [PAIR_SLOTS];
    longint        arctan_q30[CORDIC_STAGES];
    rotated_pair_t pending[$];
    int unsigned   mismatches;

    function new();
      longint unsigned expo, frac, arg, term, g;
      longint          sum, acc, t;
      int unsigned     whole;
      mismatches = 0;
      // Frequency per pair in turns per position, 10000^(-2k/HEAD_SIZE) / (2 pi).
      for (int k = 0; k < PAIR_SLOTS; k++) begin
        turn_rate[k] = '0;
        if (2 * k < HEAD_SIZE) begin
          expo  = (u64_t'(2 * k) * BASE_LOG2_Q32) / HEAD_SIZE;
          whole = 32'(expo >> 32);
          frac  = expo & 64'hFFFF_FFFF;
          arg   = (frac * LN2_Q32) >> 32;
          sum   = 64'sd1 <<< 32;
          term  = 64'd1 << 32;
          for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * arg) >> 32) / u64_t'(n);
            if (n % 2 == 1) begin
              sum -= longint'(term);
            end else begin
              sum += longint'(term);
            end
          end
          g = (sum < 0) ? 64'd0 : u64_t'(sum);
          turn_rate[k] = 32'(((g * INV_TWO_PI_Q32) >> 32) >> whole);
        end
      end
      // atan(2^-i) in Q30 from its power series, rounded half up.
      arctan_q30[0] = QUARTER_PI_Q30;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        acc = 0;
        for (int n = 0; i * (2 * n + 1) <= 60; n++) begin
          t = longint'((64'd1 << (60 - i * (2 * n + 1))) / u64_t'(2 * n + 1));
          acc += (n % 2 == 1) ? -t : t;
        end
        arctan_q30[i] = (acc + (64'sd1 <<< 29)) >>> 30;
      end
    endfunction

    function longint clip(longint v);
      return (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Works out the rotated pair for one accepted item and queues it.
    function void note_input(logic kind, sample_t xv, sample_t yv,
                             logic [POS_FIELD_W-1:0] pos, logic [PAIR_FIELD_W-1:0] k);
      bit [31:0]     phase, rounded, resid, mag;
      rpr_quad_e     quad;
      longint        z, a, b, t, da, db;
      rotated_pair_t res;
      if (2 * int'(k) >= HEAD_SIZE) begin
        res.xr = xv;
        res.yr = yv;
      end else begin
        phase = 32'(u64_t'(pos[POSITION_BITS-1:0]) * turn_rate[k]);
        if (kind) phase = 32'd0 - phase;
        rounded = phase + 32'h2000_0000;
        quad    = rpr_quad_e'(rounded[31:30]);
        resid   = phase - {quad, 30'd0};
        mag     = resid[31] ? (32'd0 - resid) : resid;
        z = longint'((u64_t'(mag) * TWO_PI_Q29) >> 31);
        if (resid[31]) z = -z;
        a = longint'(xv) <<< GUARD_BITS;
        b = longint'(yv) <<< GUARD_BITS;
        case (quad)
          QUAD_90: begin
            t = a;
            a = -b;
            b = t;
          end
          QUAD_180: begin
            a = -a;
            b = -b;
          end
          QUAD_270: begin
            t = a;
            a = b;
            b = -t;
          end
          default: ;
        endcase
        for (int i = 0; i < CORDIC_STAGES; i++) begin
          da = b >>> i;
          db = a >>> i;
          if (z >= 0) begin
            a -= da;
            b += db;
            z -= arctan_q30[i];
          end else begin
            a += da;
            b -= db;
            z += arctan_q30[i];
          end
        end
        res.xr = sample_t'(clip((a * GAIN_Q20 + (64'sd1 <<< (GUARD_BITS + 19)))
                                >>> (GUARD_BITS + 20)));
        res.yr = sample_t'(clip((b * GAIN_Q20 + (64'sd1 <<< (GUARD_BITS + 19)))
                                >>> (GUARD_BITS + 20)));
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] word);
      rotated_pair_t want;
      sample_t       got_x, got_y;
      got_x = word[DATA_BITS-1:0];
      got_y = word[2*DATA_BITS-1:DATA_BITS];
      if (pending.size() == 0) begin
        flag_error($sformatf("unexpected item x_rotated=%0d y_rotated=%0d", got_x, got_y));
      end else begin
        want = pending.pop_front();
        if (got_x !== want.xr || got_y !== want.yr)
          flag_error($sformatf("x_rotated exp %0d got %0d, y_rotated exp %0d got %0d",
                               want.xr, got_x, want.yr, got_y));
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  rope_scoreboard sb = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_done = 0;
  int unsigned stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  rotary_position_rotate_unit #(
    .HEAD_SIZE     (HEAD_SIZE),
    .POSITION_BITS (POSITION_BITS),
    .DATA_BITS     (DATA_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Both handshakes are sampled on the edge, before any driver update lands.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tuser,
                    sample_t'(s_axis_tdata[DATA_BITS-1:0]),
                    sample_t'(s_axis_tdata[2*DATA_BITS-1:DATA_BITS]),
                    s_axis_tdata[2*DATA_BITS +: POS_FIELD_W],
                    s_axis_tdata[2*DATA_BITS + POS_FIELD_W +: PAIR_FIELD_W]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_requested != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("rotary_position_rotate_unit test failed");
    $finish;
  end

  task automatic send_item(logic kind, sample_t xv, sample_t yv,
                           logic [POS_FIELD_W-1:0] pos, logic [PAIR_FIELD_W-1:0] k);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= S_TDATA_W'({k, pos, yv, xv});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    sample_t                xv, yv;
    logic [POS_FIELD_W-1:0] pos;
    repeat (count) begin
      xv  = pick_sample();
      yv  = pick_sample();
      pos = ($urandom_range(3) == 0) ? POS_FIELD_W'($urandom_range(63))
                                     : POS_FIELD_W'($urandom);
      send_item(1'($urandom), xv, yv, pos, PAIR_FIELD_W'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 38;
    rx_idle_pct = 72;
    // Pair 0 turns by one radian per position, so these walk all four quadrants.
    for (int p = 0; p < 8; p++) begin
      send_item(1'(p % 2), sample_t'(4096), sample_t'(-2048), POS_FIELD_W'(p), '0);
    end
    // Full-scale inputs rotated near 45 degrees overflow and must saturate.
    for (int kd = 0; kd < 2; kd++) begin
      send_item(1'(kd), sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX), POS_FIELD_W'(1), '0);
      send_item(1'(kd), sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN), POS_FIELD_W'(1), '0);
      send_item(1'(kd), sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), '1, '0);
      send_item(1'(kd), sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX), '1, '1);
      send_item(1'(kd), '0, '0, '1, '1);
      send_item(1'(kd), sample_t'(SAMPLE_MIN), sample_t'(-1), '0, '1);
    end
    // With 64 elements per head every 5-bit pair index lies inside the head,
    // and the position field is exactly as wide as the block uses.
    send_item(1'b1, sample_t'(12345), sample_t'(-321), 16'h8000, 5'd15);

    run_random(RANDOM_PER_PHASE);
    tx_idle_pct = 72;
    rx_idle_pct = 38;
    run_random(RANDOM_PER_PHASE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holds_requested++;
    run_random(RANDOM_PER_PHASE);
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("rotary_position_rotate_unit test passed");
    end else begin
      $display("rotary_position_rotate_unit test failed");
    end
    $finish;
  end

endmodule

FILE: rotary_position_rotate_unit.f
+incdir+design
design/rpr_pkg.sv
design/rpr_front.sv
design/rpr_cell.sv
design/rpr_gain.sv
design/rotary_position_rotate_unit.sv
bench/tb_rotary_position_rotate_unit.sv
